// ===== src/ale_pkg.sv =====
// shared types and codes for the array list engine
// command and status structs between controller and datapath; no dependencies
package ale_pkg;

    localparam int DEPTH_DEF = 32;

    // command codes, carried on s_tuser
    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_RM_FRONT  = 3'd2,
        CMD_RM_BACK   = 3'd3,
        CMD_CLEAR     = 3'd4,
        CMD_INS_SORT  = 3'd5,
        CMD_RM_VALUE  = 3'd6,
        CMD_READ_ALL  = 3'd7
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_ZERO = 3'd1,
        IDX_CNT  = 3'd2,
        IDX_INC  = 3'd3,
        IDX_DEC  = 3'd4
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } cnt_op_t;

    // read address relative to the index register
    typedef enum logic [1:0] {
        RA_PREV = 2'd0,
        RA_CUR  = 2'd1,
        RA_NEXT = 2'd2
    } rd_sel_t;

    typedef struct packed {
        idx_op_t idx_op;
        cnt_op_t cnt_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_opnd;     // write the operand rather than the read data
        logic    res_load;
        logic    res_elem;    // result carries the entry read out
        logic    res_last;
        status_t res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_at_end;     // index equals count
        logic idx1_at_end;    // index + 1 reaches count
        logic gt;             // read data greater than operand, signed
        logic eq;             // read data equals operand
        logic out_free;
    } dp_sts_t;

endpackage

// ===== src/ale_datapath.sv =====
// datapath of the array list engine: entry store, index and count, result register
// depends on ale_pkg
module ale_datapath import ale_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        opnd_load,
    input  logic [31:0] operand,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic [31:0]   opnd_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] rd_idx;
    logic [CW:0]   idx_plus1;
    logic [31:0]   wr_data;

    logic          valid_reg, valid_next;
    logic [1:0]    st_reg;
    logic [5:0]    cnt_out_reg;
    logic [4:0]    pos_reg;
    logic [31:0]   elem_reg;
    logic          last_reg;
    logic [CW+5:0] cnt_ext;
    logic [CW+4:0] idx_ext;

    assign idx_plus1 = {1'b0, idx_reg} + {{CW{1'b0}}, 1'b1};
    assign cnt_ext   = {6'd0, cnt_reg};
    assign idx_ext   = {5'd0, idx_reg};

    always_comb begin
        unique case (cmd.rd_sel)
            RA_PREV: rd_idx = idx_reg - CW'(1);
            RA_NEXT: rd_idx = idx_plus1[CW-1:0];
            default: rd_idx = idx_reg;
        endcase
    end

    assign wr_data = cmd.wr_opnd ? opnd_reg : rdata_reg;

    // single port store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[idx_reg[AW-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_idx[AW-1:0]];
        end
        if (opnd_load) begin
            opnd_reg <= operand;
        end
    end

    always_comb begin
        unique case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_CNT:  idx_next = cnt_reg;
            IDX_INC:  idx_next = idx_plus1[CW-1:0];
            IDX_DEC:  idx_next = idx_reg - CW'(1);
            default:  idx_next = idx_reg;
        endcase
        unique case (cmd.cnt_op)
            CNT_INC: cnt_next = cnt_reg + CW'(1);
            CNT_DEC: cnt_next = cnt_reg - CW'(1);
            CNT_CLR: cnt_next = '0;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    // result register
    assign sts.out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (cmd.res_load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            st_reg      <= cmd.res_status;
            cnt_out_reg <= cnt_ext[5:0];
            pos_reg     <= cmd.res_elem ? idx_ext[4:0] : 5'd0;
            elem_reg    <= cmd.res_elem ? rdata_reg : 32'd0;
            last_reg    <= cmd.res_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, elem_reg, pos_reg, cnt_out_reg, st_reg};
    assign m_tlast  = last_reg;

    assign sts.full        = (cnt_reg == CW'(DEPTH));
    assign sts.empty       = (cnt_reg == '0);
    assign sts.idx_zero    = (idx_reg == '0);
    assign sts.idx_at_end  = (idx_reg == cnt_reg);
    assign sts.idx1_at_end = (idx_plus1 >= {1'b0, cnt_reg});
    assign sts.gt          = ($signed(rdata_reg) > $signed(opnd_reg));
    assign sts.eq          = (rdata_reg == opnd_reg);

endmodule

// ===== src/ale_ctrl.sv =====
// controller of the array list engine: one-hot state machine sequencing the datapath
// depends on ale_pkg
module ale_ctrl import ale_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [2:0] command,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_INS_CHK  = 10'b00_0000_0010,
        S_INS_CMP  = 10'b00_0000_0100,
        S_FIND_RD  = 10'b00_0000_1000,
        S_FIND_CMP = 10'b00_0001_0000,
        S_SH_CHK   = 10'b00_0010_0000,
        S_SH_WR    = 10'b00_0100_0000,
        S_RA_RD    = 10'b00_1000_0000,
        S_RA_OUT   = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    state_t  state_reg, state_next;
    cmd_t    op_reg, op_next;
    status_t st_reg, st_next;
    cmd_t    in_op;

    assign in_op    = cmd_t'(command);
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        st_next        = st_reg;
        cmd            = '0;
        cmd.idx_op     = IDX_HOLD;
        cmd.cnt_op     = CNT_HOLD;
        cmd.rd_sel     = RA_CUR;
        cmd.res_status = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next = in_op;
                    st_next = ST_OK;
                    unique case (in_op)
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_SORT: begin
                            if (sts.full) begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end else begin
                                cmd.idx_op = IDX_CNT;
                                state_next = S_INS_CHK;
                            end
                        end
                        CMD_RM_FRONT: begin
                            cmd.idx_op = IDX_ZERO;
                            if (sts.empty) begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SH_CHK;
                            end
                        end
                        CMD_RM_BACK: begin
                            if (sts.empty) begin
                                st_next = ST_EMPTY;
                            end else begin
                                cmd.cnt_op = CNT_DEC;
                            end
                            state_next = S_DONE;
                        end
                        CMD_CLEAR: begin
                            cmd.cnt_op = CNT_CLR;
                            state_next = S_DONE;
                        end
                        CMD_RM_VALUE: begin
                            cmd.idx_op = IDX_ZERO;
                            if (sts.empty) begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        default: begin
                            cmd.idx_op = IDX_ZERO;
                            if (sts.empty) begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_RA_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_CHK: begin
                if (sts.idx_zero || op_reg == CMD_INS_BACK) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_opnd = 1'b1;
                    cmd.cnt_op  = CNT_INC;
                    state_next  = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_PREV;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                cmd.wr_en = 1'b1;
                if (op_reg == CMD_INS_FRONT || sts.gt) begin
                    cmd.idx_op = IDX_DEC;
                    state_next = S_INS_CHK;
                end else begin
                    cmd.wr_opnd = 1'b1;
                    cmd.cnt_op  = CNT_INC;
                    state_next  = S_DONE;
                end
            end
            S_FIND_RD: begin
                if (sts.idx_at_end) begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FIND_CMP;
                end
            end
            S_FIND_CMP: begin
                if (sts.eq) begin
                    state_next = S_SH_CHK;
                end else begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_FIND_RD;
                end
            end
            S_SH_CHK: begin
                if (sts.idx1_at_end) begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_NEXT;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_INC;
                state_next = S_SH_CHK;
            end
            S_RA_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_RA_OUT;
            end
            S_RA_OUT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    cmd.res_elem = 1'b1;
                    cmd.res_last = sts.idx1_at_end;
                    if (sts.idx1_at_end) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_op = IDX_INC;
                        state_next = S_RA_RD;
                    end
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_last   = 1'b1;
                    cmd.res_status = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_INS_FRONT;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            st_reg    <= st_next;
        end
    end

endmodule

// ===== src/array_list_engine_unit.sv =====
// top level of the array list engine: controller plus datapath behind stream ports
// depends on ale_pkg, ale_ctrl and ale_datapath
//
// an ordered list of up to DEPTH signed 32-bit entries kept packed from index 0 in a
// single-port store with a registered read, plus an occupancy count. one command is
// taken at a time: s_tready is high only while the controller is idle. a command is
// one transfer with the operation code on s_tuser and the operand on s_tdata. front
// and sorted insert shift entries up one at a time, remove front closes entries up
// one at a time, and remove value searches entry by entry and then closes entries
// up behind a match. read all gives one result transfer per entry, tlast on the
// final one. every command ends in at least one result transfer carrying status
// and the count after the command; a result waits in the output register while
// the next command is taken. the store is not cleared at reset, as only entries
// below the count are read.
module array_list_engine_unit import ale_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [2:0]  s_tuser,   // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [7:2] count, [12:8] position, [44:13] element, [47:45] zero
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    logic    s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    // sequencing of inserts, removals and read out
    ale_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // store, index and count registers, result register
    ale_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .opnd_load (s_xfer),
        .operand   (s_tdata),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // count cannot be both zero and at capacity
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dp_sts.full && dp_sts.empty))
        else $error("list reported both full and empty");

    // a clear leaves the list empty
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser == CMD_CLEAR) |=> dp_sts.empty)
        else $error("list not empty after clear");

    // an insert into a full list is refused and leaves it full
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && dp_sts.full && (s_tuser == CMD_INS_FRONT || s_tuser == CMD_INS_BACK
            || s_tuser == CMD_INS_SORT)) |=> dp_sts.full)
        else $error("insert changed a full list");

    // only read out results come without tlast, and they carry status ok
    a_run_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[1:0] == ST_OK))
        else $error("result inside a run with bad status");

endmodule
